// ===== hw/rtl/ttlnc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlnc_pkg: shared types and constants of the TTL name cache
// Word formats, entry record, operation codes and controller handshake types.
// ----------------------------------------------------------------------------
package ttlnc_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam logic [31:0] TTL_RESET = 32'd60000;
   localparam int ORDER_W = 64;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  partition_tag;
      logic [63:0] host_tag;
      logic [15:0] port_number;
      logic [47:0] now_ms;
      logic [3:0]  address_count;
      logic [63:0] address_payload;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [3:0]  found_count;
      logic [63:0] found_payload;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         partition_tag;
      logic [63:0]        host_tag;
      logic [15:0]        port_number;
      logic [63:0]        payload;
      logic [3:0]         count;
      logic [47:0]        stamp;
      logic [ORDER_W-1:0] order;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic load;
      logic clear_all;
      logic scan_step;
      logic commit;
      logic result_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic is_scan;
      logic is_store;
      logic issue_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/ttlnc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlnc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ttlnc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ttlnc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlnc_ctrl: sequencing controller of the TTL name cache
// Accepts one request word, steps the datapath through its scan and commit,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module ttlnc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ttlnc_pkg::dp_status_type status,
   output ttlnc_pkg::ctrl_cmd_type  cmd
);
   import ttlnc_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_clear) begin
               cmd.clear_all = 1'b1;
               state_in = S_RESULT;
            end else if (status.is_scan) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.issue_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = status.is_store ? S_COMMIT : S_RESULT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/ttlnc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlnc_datapath: entry storage, scan logic and result register
// Holds the entry RAM and valid bits, evaluates expiry, key match and
// eviction choice one entry per cycle, and commits store updates.
// ----------------------------------------------------------------------------
module ttlnc_datapath #(
   parameter int ENTRIES = ttlnc_pkg::ENTRIES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ttlnc_pkg::ctrl_cmd_type  cmd,
   output ttlnc_pkg::dp_status_type status,
   input  ttlnc_pkg::req_type       req_data,
   input  logic [31:0]              ttl_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ttlnc_pkg::rsp_type       rsp_data
);
   import ttlnc_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

   req_type            req_ff;
   logic [IW-1:0]      addr_ff, addr_in;
   logic               pend_ff;
   logic [IW-1:0]      pend_idx_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]      live_ff, live_in;
   logic [ORDER_W-1:0] order_ff, order_in;

   logic               hit_ff, hit_in;
   logic [3:0]         hit_count_ff, hit_count_in;
   logic [63:0]        hit_payload_ff, hit_payload_in;
   logic               match_ff, match_in;
   logic [IW-1:0]      match_idx_ff, match_idx_in;
   logic [ORDER_W-1:0] match_order_ff, match_order_in;
   logic               free_ff, free_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic               vic_ff, vic_in;
   logic [IW-1:0]      vic_idx_ff, vic_idx_in;
   logic [47:0]        vic_stamp_ff, vic_stamp_in;
   logic [ORDER_W-1:0] vic_order_ff, vic_order_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   entry_type          rd_entry;
   entry_type          wr_entry;
   logic [IW-1:0]      wr_idx;
   logic               slot_valid;
   logic               key_eq;
   logic [48:0]        age;
   logic               expired;
   logic               older;
   logic               full;

   ttlnc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES),
      .AW    (IW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (wr_idx),
      .wr_data (wr_entry),
      .rd_en   (cmd.scan_step),
      .rd_addr (addr_ff),
      .rd_data (rd_entry)
   );

   assign slot_valid = valid_ff[pend_idx_ff];
   assign key_eq = (rd_entry.partition_tag == req_ff.partition_tag) &&
                   (rd_entry.host_tag == req_ff.host_tag) &&
                   (rd_entry.port_number == req_ff.port_number);
   assign age = {1'b0, req_ff.now_ms} - {1'b0, rd_entry.stamp};
   assign expired = slot_valid && !age[48] && (age[47:0] >= {16'd0, ttl_ms});
   assign older = !vic_ff || (rd_entry.stamp < vic_stamp_ff) ||
                  ((rd_entry.stamp == vic_stamp_ff) && (rd_entry.order < vic_order_ff));
   assign full = (live_ff == FULL_CNT);

   always_comb begin
      wr_entry.partition_tag = req_ff.partition_tag;
      wr_entry.host_tag = req_ff.host_tag;
      wr_entry.port_number = req_ff.port_number;
      wr_entry.payload = req_ff.address_payload;
      wr_entry.count = req_ff.address_count;
      wr_entry.stamp = req_ff.now_ms;
      if (match_ff) begin
         wr_entry.order = match_order_ff;
         wr_idx = match_idx_ff;
      end else begin
         wr_entry.order = order_ff;
         wr_idx = full ? vic_idx_ff : free_idx_ff;
      end
   end

   always_comb begin
      addr_in = addr_ff;
      valid_in = valid_ff;
      live_in = live_ff;
      order_in = order_ff;
      hit_in = hit_ff;
      hit_count_in = hit_count_ff;
      hit_payload_in = hit_payload_ff;
      match_in = match_ff;
      match_idx_in = match_idx_ff;
      match_order_in = match_order_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      vic_in = vic_ff;
      vic_idx_in = vic_idx_ff;
      vic_stamp_in = vic_stamp_ff;
      vic_order_in = vic_order_ff;

      if (cmd.load) begin
         addr_in = '0;
         hit_in = 1'b0;
         match_in = 1'b0;
         free_in = 1'b0;
         vic_in = 1'b0;
      end
      if (cmd.scan_step) begin
         addr_in = addr_ff + IW'(1);
      end
      if (cmd.clear_all) begin
         valid_in = '0;
         live_in = '0;
      end

      if (pend_ff) begin
         if (req_ff.operation == OP_LOOKUP) begin
            if (expired) begin
               valid_in[pend_idx_ff] = 1'b0;
               live_in = live_ff - CW'(1);
            end else if (slot_valid && key_eq && !hit_ff) begin
               hit_in = 1'b1;
               hit_count_in = rd_entry.count;
               hit_payload_in = rd_entry.payload;
            end
         end else begin
            if (slot_valid && key_eq && !match_ff) begin
               match_in = 1'b1;
               match_idx_in = pend_idx_ff;
               match_order_in = rd_entry.order;
            end
            if (!slot_valid && !free_ff) begin
               free_in = 1'b1;
               free_idx_in = pend_idx_ff;
            end
            if (slot_valid && older) begin
               vic_in = 1'b1;
               vic_idx_in = pend_idx_ff;
               vic_stamp_in = rd_entry.stamp;
               vic_order_in = rd_entry.order;
            end
         end
      end

      if (cmd.commit && !match_ff) begin
         valid_in[wr_idx] = 1'b1;
         order_in = order_ff + ORDER_W'(1);
         if (!full) begin
            live_in = live_ff + CW'(1);
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
         rsp_in.hit = hit_ff;
         rsp_in.found_count = hit_ff ? hit_count_ff : 4'd0;
         rsp_in.found_payload = hit_ff ? hit_payload_ff : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         valid_ff <= '0;
         live_ff <= '0;
         order_ff <= '0;
         hit_ff <= 1'b0;
         match_ff <= 1'b0;
         free_ff <= 1'b0;
         vic_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.scan_step;
         valid_ff <= valid_in;
         live_ff <= live_in;
         order_ff <= order_in;
         hit_ff <= hit_in;
         match_ff <= match_in;
         free_ff <= free_in;
         vic_ff <= vic_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      addr_ff <= addr_in;
      pend_idx_ff <= addr_ff;
      hit_count_ff <= hit_count_in;
      hit_payload_ff <= hit_payload_in;
      match_idx_ff <= match_idx_in;
      match_order_ff <= match_order_in;
      free_idx_ff <= free_idx_in;
      vic_idx_ff <= vic_idx_in;
      vic_stamp_ff <= vic_stamp_in;
      vic_order_ff <= vic_order_in;
      rsp_ff <= rsp_in;
   end

   assign status.is_clear = (req_ff.operation == OP_CLEAR);
   assign status.is_scan = (req_ff.operation == OP_LOOKUP) ||
                           ((req_ff.operation == OP_STORE) && (req_ff.address_count != 4'd0));
   assign status.is_store = (req_ff.operation == OP_STORE);
   assign status.issue_last = (addr_ff == LAST_IDX);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/ttl_name_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_name_cache: fully associative name cache with time-to-live expiry
// Lookup, store and clear over ENTRIES slots held in one entry RAM.
// ----------------------------------------------------------------------------
// One request word is handled at a time. A lookup or a store with a nonzero
// address count scans every slot through the entry RAM read port, one slot per
// cycle, then drains the last read, and a store then commits its write. Clear and
// the remaining requests go from decode straight to the result stage. The
// result sits in an output register, and the next request is accepted as soon
// as it has been loaded there. Lookups drop expired entries while they scan.
// The TTL register may be written only while the cache is idle.
module ttl_name_cache #(
   parameter int ENTRIES = ttlnc_pkg::ENTRIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ttlnc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ttlnc_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_data
);
   import ttlnc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [31:0]   ttl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TTL_RESET;
      end else if (csr_valid && csr_ready) begin
         ttl_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   ttlnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ttlnc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .ttl_ms    (ttl_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // An accepted word keeps the input closed until its result is registered.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // A miss never carries stale entry data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.found_count == 4'd0 &&
                                     rsp_data.found_payload == 64'd0)
      else $error("miss result carries data");

   // Loading a result never drops a word still waiting at the output.
   assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> !rsp_valid || !rsp_stall)
      else $error("result overwritten while stalled");

endmodule

// ===== sim/ttl_name_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_name_cache_tb: self-checking regression for the TTL name cache
// Directed words cover the field extremes, every operation, refresh in place,
// the expiry boundary, time running backward and the TTL extremes. Random
// traffic then runs over small key pools so that hits, refreshes, evictions
// and expiry are all frequent, with sender gaps and receiver stalls. A shadow
// copy of the table predicts every result word.
// ----------------------------------------------------------------------------
module ttl_name_cache_tb;
   import ttlnc_pkg::*;

   localparam int SLOTS = ENTRIES_DEFAULT;
   localparam int SETTLE_CYCLES = SLOTS + 8;
   localparam int CYCLE_LIMIT = 600000;
   localparam int POOL_MAX = 28;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      bit          used;
      logic [7:0]  part;
      logic [63:0] host;
      logic [15:0] port;
      logic [63:0] payload;
      logic [3:0]  count;
      logic [47:0] stamp;
      int unsigned rank;
   } shadow_slot_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   shadow_slot_type shadow_slots [SLOTS];
   int unsigned  live_count;
   logic [31:0]  ttl_ms;
   rsp_type      pending_answers [$];
   rsp_type      answer_due;
   int           error_count = 0;
   int           burst_left = 0;
   int           cycle_count;
   logic [15:0]  stall_pattern;
   logic [5:0]   stall_phase;
   logic [47:0]  sim_now;

   int          pool_size;
   logic [7:0]  pool_part [POOL_MAX];
   logic [63:0] pool_host [POOL_MAX];
   logic [15:0] pool_port [POOL_MAX];

   ttl_name_cache dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   task automatic report_error(input string what);
      error_count++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   function automatic int find_slot(input req_type w);
      int i;
      for (i = 0; i < SLOTS; i++) begin
         if (shadow_slots[i].used && shadow_slots[i].part == w.partition_tag &&
             shadow_slots[i].host == w.host_tag && shadow_slots[i].port == w.port_number) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void drop_slot(input int s);
      int i;
      int unsigned r;
      r = shadow_slots[s].rank;
      shadow_slots[s].used = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         if (shadow_slots[i].used && shadow_slots[i].rank > r) begin
            shadow_slots[i].rank--;
         end
      end
      if (live_count > 0) begin
         live_count--;
      end
   endfunction

   function automatic rsp_type resolve_word(input req_type w);
      rsp_type r;
      int i;
      int s;
      int victim;
      r = '0;
      case (w.operation)
         OP_LOOKUP: begin
            for (i = 0; i < SLOTS; i++) begin
               if (shadow_slots[i].used && w.now_ms >= shadow_slots[i].stamp &&
                   (w.now_ms - shadow_slots[i].stamp) >= {16'd0, ttl_ms}) begin
                  drop_slot(i);
               end
            end
            s = find_slot(w);
            if (s >= 0) begin
               r.hit = 1'b1;
               r.found_count = shadow_slots[s].count;
               r.found_payload = shadow_slots[s].payload;
            end
         end
         OP_STORE: begin
            if (w.address_count != 4'd0) begin
               s = find_slot(w);
               if (s >= 0) begin
                  shadow_slots[s].payload = w.address_payload;
                  shadow_slots[s].count = w.address_count;
                  shadow_slots[s].stamp = w.now_ms;
               end else begin
                  if (live_count >= SLOTS) begin
                     victim = -1;
                     for (i = 0; i < SLOTS; i++) begin
                        if (shadow_slots[i].used && (victim < 0 ||
                            shadow_slots[i].stamp < shadow_slots[victim].stamp ||
                            (shadow_slots[i].stamp == shadow_slots[victim].stamp &&
                             shadow_slots[i].rank < shadow_slots[victim].rank))) begin
                           victim = i;
                        end
                     end
                     if (victim >= 0) begin
                        drop_slot(victim);
                     end
                  end
                  for (i = 0; i < SLOTS; i++) begin
                     if (!shadow_slots[i].used) begin
                        shadow_slots[i].used = 1'b1;
                        shadow_slots[i].part = w.partition_tag;
                        shadow_slots[i].host = w.host_tag;
                        shadow_slots[i].port = w.port_number;
                        shadow_slots[i].payload = w.address_payload;
                        shadow_slots[i].count = w.address_count;
                        shadow_slots[i].stamp = w.now_ms;
                        shadow_slots[i].rank = live_count;
                        live_count++;
                        break;
                     end
                  end
               end
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < SLOTS; i++) begin
               shadow_slots[i].used = 1'b0;
            end
            live_count = 0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic req_type make_word(input logic [1:0] op, input logic [7:0] part,
                                         input logic [63:0] host, input logic [15:0] port,
                                         input logic [47:0] now, input logic [3:0] cnt,
                                         input logic [63:0] pay);
      req_type w;
      w.operation = op;
      w.partition_tag = part;
      w.host_tag = host;
      w.port_number = port;
      w.now_ms = now;
      w.address_count = cnt;
      w.address_payload = pay;
      return w;
   endfunction

   // The valid stays high after an acceptance so that a following word in the
   // same burst is offered without a bubble.
   task automatic send_word(input req_type w);
      int gap;
      rsp_type answer;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      answer = resolve_word(w);
      pending_answers.insert(pending_answers.size(), answer);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ttl(input logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      ttl_ms = value;
   endtask

   task automatic build_key_pool();
      int k;
      pool_size = $urandom_range(4, POOL_MAX);
      for (k = 0; k < pool_size; k++) begin
         pool_part[k] = 8'($urandom);
         pool_host[k] = {$urandom, $urandom};
         pool_port[k] = 16'($urandom);
         if (k > 0 && $urandom_range(0, 3) == 0) begin
            pool_part[k] = pool_part[k-1];
            pool_host[k] = pool_host[k-1];
            pool_port[k] = pool_port[k-1];
            case ($urandom_range(0, 2))
               0: pool_part[k] = pool_part[k] ^ 8'(1 << $urandom_range(0, 7));
               1: pool_host[k] = pool_host[k] ^ (64'd1 << $urandom_range(0, 63));
               default: pool_port[k] = pool_port[k] ^ 16'(1 << $urandom_range(0, 15));
            endcase
         end
      end
   endtask

   task automatic test_lookup_store_clear();
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'd0, 4'd0, 64'd0));
      send_word(make_word(OP_STORE, 8'h00, 64'd0, 16'h0000, 48'd0, 4'hF, '1));
      send_word(make_word(OP_STORE, 8'hFF, '1, 16'hFFFF, 48'd0, 4'd1, 64'd0));
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'd10, 4'd0, 64'd0));
      send_word(make_word(OP_LOOKUP, 8'hFF, '1, 16'hFFFF, 48'd10, 4'hF, '1));
      send_word(make_word(OP_STORE, 8'h00, 64'd0, 16'h0000, 48'd10, 4'd0,
                          64'h5555_5555_5555_5555));
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'd12, 4'd0, 64'd0));
      send_word(make_word(OP_STORE, 8'h00, 64'd0, 16'h0000, 48'd20, 4'd7,
                          64'hAAAA_AAAA_AAAA_AAAA));
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'd20, 4'd0, 64'd0));
      send_word(make_word(OP_UNUSED, 8'hFF, '1, 16'hFFFF, '1, 4'hF, '1));
      send_word(make_word(OP_CLEAR, 8'h00, 64'd0, 16'h0000, 48'd20, 4'd0, 64'd0));
      send_word(make_word(OP_LOOKUP, 8'hFF, '1, 16'hFFFF, 48'd20, 4'd0, 64'd0));
   endtask

   task automatic test_expiry_boundary();
      send_word(make_word(OP_STORE, 8'h00, 64'd0, 16'h0000, 48'd100, 4'd3,
                          64'h0123_4567_89AB_CDEF));
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'd60099, 4'd0, 64'd0));
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'd60100, 4'd0, 64'd0));
      send_word(make_word(OP_STORE, 8'hFF, '1, 16'hFFFF, '1, 4'd9, 64'hFEDC_BA98_7654_3210));
      send_word(make_word(OP_LOOKUP, 8'hFF, '1, 16'hFFFF, 48'd5, 4'd0, 64'd0));
   endtask

   task automatic test_ttl_extremes();
      write_ttl(32'd0);
      send_word(make_word(OP_STORE, 8'h00, 64'd0, 16'h0000, 48'd500, 4'd2, 64'd22));
      send_word(make_word(OP_STORE, 8'hFF, '1, 16'hFFFF, 48'd900, 4'd4, 64'd44));
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'd500, 4'd0, 64'd0));
      send_word(make_word(OP_LOOKUP, 8'hFF, '1, 16'hFFFF, 48'd500, 4'd0, 64'd0));
      write_ttl(32'hFFFF_FFFF);
      send_word(make_word(OP_STORE, 8'h00, 64'd0, 16'h0000, 48'd0, 4'd5, 64'd55));
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'h0000_FFFF_FFFE, 4'd0, 64'd0));
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'h0000_FFFF_FFFF, 4'd0, 64'd0));
      write_ttl(32'd1);
      send_word(make_word(OP_STORE, 8'h00, 64'd0, 16'h0000, 48'd7, 4'd6, 64'd66));
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'd7, 4'd0, 64'd0));
      send_word(make_word(OP_LOOKUP, 8'h00, 64'd0, 16'h0000, 48'd8, 4'd0, 64'd0));
   endtask

   task automatic run_random_phase(input logic [31:0] ttl_value, input int word_total);
      int n;
      int pick;
      int key;
      logic [31:0] step_max;
      logic [1:0] op;
      logic [3:0] cnt;
      req_type w;
      write_ttl(ttl_value);
      build_key_pool();
      step_max = (ttl_value / 3) + 32'd1;
      for (n = 0; n < word_total; n++) begin
         pick = $urandom_range(0, 9);
         if (pick >= 3 && pick <= 7) begin
            sim_now = sim_now + 48'($urandom_range(1, step_max));
         end else if (pick == 8) begin
            sim_now = sim_now - 48'($urandom_range(1, step_max));
         end else if (pick == 9) begin
            if ($urandom_range(0, 1) == 0) begin
               sim_now = sim_now + {16'd0, ttl_value};
            end else begin
               sim_now = {16'($urandom), $urandom};
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 46) begin
            op = OP_LOOKUP;
         end else if (pick < 97) begin
            op = OP_STORE;
         end else if (pick < 98) begin
            op = OP_CLEAR;
         end else begin
            op = OP_UNUSED;
         end
         cnt = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
         key = $urandom_range(0, pool_size - 1);
         if ($urandom_range(0, 19) == 0) begin
            w = make_word(op, 8'($urandom), {$urandom, $urandom}, 16'($urandom), sim_now,
                          cnt, {$urandom, $urandom});
         end else begin
            w = make_word(op, pool_part[key], pool_host[key], pool_port[key], sim_now,
                          cnt, {$urandom, $urandom});
         end
         send_word(w);
      end
   endtask

   task automatic test_random_traffic();
      sim_now = {16'($urandom), $urandom};
      run_random_phase(TTL_RESET, 325);
      run_random_phase(32'd1, 325);
      run_random_phase(32'hFFFF_FFFF, 325);
      run_random_phase(32'($urandom_range(2, 300)), 325);
      run_random_phase($urandom, 325);
      run_random_phase(32'($urandom_range(300, 5000)), 325);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_pattern <= 16'd0;
         stall_phase <= 6'd0;
      end else begin
         stall_phase <= stall_phase + 6'd1;
         if (stall_phase == 6'd0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern <= 16'd0;
               1: stall_pattern <= 16'($urandom & $urandom) & 16'hFFFE;
               2: stall_pattern <= 16'($urandom) & 16'hFFFE;
               default: stall_pattern <= 16'($urandom | $urandom) & 16'hFFFE;
            endcase
         end
         rsp_stall <= stall_pattern[stall_phase[3:0]];
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_answers.size() == 0) begin
            report_error("result word with no expectation pending");
         end else begin
            answer_due = pending_answers.pop_front();
            if (rsp_data.hit !== answer_due.hit) begin
               report_error($sformatf("hit %0b, expected %0b", rsp_data.hit, answer_due.hit));
            end
            if (rsp_data.found_count !== answer_due.found_count) begin
               report_error($sformatf("found_count %0d, expected %0d",
                                      rsp_data.found_count, answer_due.found_count));
            end
            if (rsp_data.found_payload !== answer_due.found_payload) begin
               report_error($sformatf("found_payload %h, expected %h",
                                      rsp_data.found_payload, answer_due.found_payload));
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ttl_name_cache regression: fail");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_data <= 32'd0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_slots[i].used = 1'b0;
      end
      live_count = 0;
      ttl_ms = TTL_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_lookup_store_clear();
      test_expiry_boundary();
      test_ttl_extremes();
      test_random_traffic();
      drain();

      if (error_count == 0) begin
         $display("ttl_name_cache regression: pass");
      end else begin
         $display("ttl_name_cache regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ttlnc_pkg.sv
hw/rtl/ttlnc_ram.sv
hw/rtl/ttlnc_ctrl.sv
hw/rtl/ttlnc_datapath.sv
hw/rtl/ttl_name_cache.sv
sim/ttl_name_cache_tb.sv
